### src/uwt_pkg.sv
// Shared types, constants and the delimiter classifier of the word tokenizer.
package uwt_pkg;

  localparam int WORD_NUMBER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF       = 4;

  localparam int BYTE_W      = 8;
  localparam int WORD_NUM_W  = 16;
  localparam int NUM_SEQS    = 19;
  localparam int BUF_DEPTH   = 6;
  localparam int CNT_W       = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [BUF_DEPTH-1:0] win_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_WORD,
    ACT_DELIM,
    ACT_END
  } act_kind_t;

  // one queue entry: what the front decided, plus end-of-item marker
  typedef struct packed {
    act_kind_t kind;
    byte_t     data;
    logic      eos;
  } act_t;

  typedef struct packed {
    logic             pend;
    logic             is_delim;
    logic [CNT_W-1:0] len;
  } cls_t;

  typedef struct packed {
    byte_t                 word_byte;
    logic                  first_of_word;
    logic                  last_of_word;
    logic [WORD_NUM_W-1:0] word_number;
    logic                  last_of_run;
  } res_t;

  localparam logic [CNT_W-1:0] SEQ_LEN [NUM_SEQS] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd6, 3'd6
  };

  // full-width punctuation, tried in this order
  localparam byte_t SEQ_BYTES [NUM_SEQS][BUF_DEPTH] = '{
    '{8'hEF, 8'hBC, 8'h8C, 8'h00, 8'h00, 8'h00},
    '{8'hE3, 8'h80, 8'h82, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 8'hBC, 8'h81, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 8'hBC, 8'h9F, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 8'hBC, 8'h9B, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 8'hBC, 8'h9A, 8'h00, 8'h00, 8'h00},
    '{8'hE3, 8'h80, 8'h81, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 8'hBC, 8'h88, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 8'hBC, 8'h89, 8'h00, 8'h00, 8'h00},
    '{8'hE3, 8'h80, 8'h8A, 8'h00, 8'h00, 8'h00},
    '{8'hE3, 8'h80, 8'h8B, 8'h00, 8'h00, 8'h00},
    '{8'hE3, 8'h80, 8'h90, 8'h00, 8'h00, 8'h00},
    '{8'hE3, 8'h80, 8'h91, 8'h00, 8'h00, 8'h00},
    '{8'hE2, 8'h80, 8'h9C, 8'h00, 8'h00, 8'h00},
    '{8'hE2, 8'h80, 8'h9D, 8'h00, 8'h00, 8'h00},
    '{8'hE2, 8'h80, 8'h98, 8'h00, 8'h00, 8'h00},
    '{8'hE2, 8'h80, 8'h99, 8'h00, 8'h00, 8'h00},
    '{8'hE2, 8'h80, 8'h94, 8'hE2, 8'h80, 8'h94},
    '{8'hE2, 8'h80, 8'hA6, 8'hE2, 8'h80, 8'hA6}
  };

  function automatic logic uwt_ascii_delim(input byte_t c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20) ||
           ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
           ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
  endfunction

  // decide on the head of the window: word byte, delimiter of len bytes, or pend
  function automatic cls_t uwt_classify(input win_t win, input logic [CNT_W-1:0] cnt,
                                        input logic eot);
    cls_t r;
    logic found;
    logic hit;
    r = '{pend: 1'b0, is_delim: 1'b0, len: CNT_W'(1)};
    found = 1'b0;
    if (uwt_ascii_delim(win[0])) begin
      r.is_delim = 1'b1;
      found = 1'b1;
    end
    for (int s = 0; s < NUM_SEQS; s++) begin
      hit = 1'b1;
      for (int k = 0; k < BUF_DEPTH; k++) begin
        if ((k < cnt) && (k < SEQ_LEN[s]) && (win[k] != SEQ_BYTES[s][k])) begin
          hit = 1'b0;
        end
      end
      if (!found && hit) begin
        if (cnt >= SEQ_LEN[s]) begin
          r.is_delim = 1'b1;
          r.len = SEQ_LEN[s];
          found = 1'b1;
        end else if (!eot) begin
          r.pend = 1'b1;
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

### src/uwt_if.sv
// Valid/ready channel interfaces for text bytes in and word bytes out.
interface uwt_in_if;
  import uwt_pkg::*;
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface uwt_out_if;
  import uwt_pkg::*;
  logic                  valid;
  logic                  ready;
  byte_t                 word_byte;
  logic                  first_of_word;
  logic                  last_of_word;
  logic [WORD_NUM_W-1:0] word_number;
  logic                  last_of_run;
  modport source (output valid, word_byte, first_of_word, last_of_word, word_number,
                  last_of_run, input ready);
  modport sink (input valid, word_byte, first_of_word, last_of_word, word_number,
                last_of_run, output ready);
endinterface

### src/uwt_front.sv
// Front end: lookahead window, sequence matching, one decision per cycle into the queue while it is not full.
module uwt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  uwt_pkg::byte_t            in_byte,
  input  logic                      in_eot,
  output logic                      q_push,
  output uwt_pkg::act_t             q_item,
  input  logic                      q_full
);
  import uwt_pkg::*;

  win_t             buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             eot_r, eot_nxt;
  logic             open_r, open_nxt;

  cls_t             c0, c1;
  win_t             rem, base;
  logic [CNT_W-1:0] rem_cnt, base_cnt;
  logic             decide, rem_done, fire, drop_now, closing, acc;

  always_comb begin
    c0 = uwt_classify(buf_r, cnt_r, eot_r);
    decide = (cnt_r != '0) && !c0.pend;

    rem = buf_r;
    case (c0.len)
      CNT_W'(3): begin
        for (int i = 0; i < BUF_DEPTH - 3; i++) rem[i] = buf_r[i+3];
      end
      CNT_W'(6): rem = buf_r;
      default: begin
        for (int i = 0; i < BUF_DEPTH - 1; i++) rem[i] = buf_r[i+1];
      end
    endcase
    rem_cnt  = cnt_r - c0.len;
    c1       = uwt_classify(rem, rem_cnt, eot_r);
    rem_done = (rem_cnt == '0) || c1.pend;

    q_item.data = buf_r[0];
    q_item.eos  = 1'b1;
    q_item.kind = ACT_NONE;
    if (decide) begin
      q_item.kind = c0.is_delim ? ACT_DELIM : ACT_WORD;
      q_item.eos  = !eot_r && rem_done;
    end else if (eot_r) begin
      q_item.kind = ACT_END;
    end

    q_push   = open_r;
    fire     = open_r && !q_full;
    drop_now = fire && decide;
    closing  = fire && q_item.eos;
    in_ready = !open_r || closing;
    acc      = in_valid && in_ready;

    base     = drop_now ? rem : buf_r;
    base_cnt = drop_now ? rem_cnt : cnt_r;
    buf_nxt  = base;
    cnt_nxt  = base_cnt;
    if (acc) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        if (CNT_W'(i) == base_cnt) buf_nxt[i] = in_byte;
      end
      cnt_nxt = base_cnt + CNT_W'(1);
    end

    eot_nxt  = acc ? in_eot : (closing ? 1'b0 : eot_r);
    open_nxt = acc ? 1'b1 : (closing ? 1'b0 : open_r);
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      eot_r  <= 1'b0;
      open_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      eot_r  <= eot_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

### src/uwt_queue.sv
// Short register FIFO of decisions between front and back.
module uwt_queue #(
  parameter int DEPTH = uwt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uwt_pkg::act_t push_item,
  output logic          full,
  input  logic          pop,
  output uwt_pkg::act_t pop_item,
  output logic          not_empty
);
  import uwt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  act_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r;
  logic          do_push, do_pop;

  assign full      = (fill_r == CW'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      fill_r <= fill_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

### src/uwt_back.sv
// Back end: held byte, word counter, run-end tagging and the output register.
module uwt_back #(
  parameter int WORD_NUMBER_WIDTH = uwt_pkg::WORD_NUMBER_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  uwt_pkg::act_t q_item,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output uwt_pkg::res_t out_res
);
  import uwt_pkg::*;

  byte_t                        held_r, held_nxt;
  logic                         held_v_r, held_v_nxt;
  logic                         held_first_r, held_first_nxt;
  logic [WORD_NUMBER_WIDTH-1:0] wcnt_r, wcnt_nxt;
  res_t                         cand_r, cand_nxt;
  logic                         cand_v_r, cand_v_nxt;
  logic                         cand_final_r, cand_final_nxt;
  res_t                         out_r, out_nxt;
  logic                         out_v_r, out_v_nxt;

  res_t res;
  logic res_v, out_free, move;

  always_comb begin
    res_v = q_valid && held_v_r && (q_item.kind != ACT_NONE);
    res.word_byte     = held_r;
    res.first_of_word = held_first_r;
    res.last_of_word  = (q_item.kind != ACT_WORD);
    res.word_number   = WORD_NUM_W'(wcnt_r);
    res.last_of_run   = 1'b0;

    out_free = !out_v_r || out_ready;
    move  = cand_v_r && out_free && (cand_final_r || (q_valid && (res_v || q_item.eos)));
    q_pop = q_valid && (out_free || !(cand_v_r && (res_v || q_item.eos || cand_final_r)));

    held_nxt       = held_r;
    held_v_nxt     = held_v_r;
    held_first_nxt = held_first_r;
    wcnt_nxt       = wcnt_r;
    if (q_pop) begin
      case (q_item.kind)
        ACT_WORD: begin
          held_nxt       = q_item.data;
          held_first_nxt = !held_v_r;
          held_v_nxt     = 1'b1;
        end
        ACT_DELIM: begin
          if (held_v_r && (wcnt_r != '1)) wcnt_nxt = wcnt_r + WORD_NUMBER_WIDTH'(1);
          held_v_nxt     = 1'b0;
          held_first_nxt = 1'b0;
        end
        ACT_END: begin
          wcnt_nxt       = '0;
          held_v_nxt     = 1'b0;
          held_first_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    cand_nxt       = cand_r;
    cand_v_nxt     = cand_v_r;
    cand_final_nxt = cand_final_r;
    if (q_pop && res_v) begin
      cand_nxt       = res;
      cand_v_nxt     = 1'b1;
      cand_final_nxt = q_item.eos;
    end else if (move) begin
      cand_v_nxt     = 1'b0;
      cand_final_nxt = 1'b0;
    end

    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_ready;
    if (move) begin
      out_nxt             = cand_r;
      out_nxt.last_of_run = cand_final_r || (q_item.eos && !res_v);
      out_v_nxt           = 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    cand_r <= cand_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      held_v_r     <= 1'b0;
      held_first_r <= 1'b0;
      wcnt_r       <= '0;
      cand_v_r     <= 1'b0;
      cand_final_r <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      held_v_r     <= held_v_nxt;
      held_first_r <= held_first_nxt;
      wcnt_r       <= wcnt_nxt;
      cand_v_r     <= cand_v_nxt;
      cand_final_r <= cand_final_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

endmodule

### src/utf8_word_tokenizer_core.sv
// Splits a UTF-8 byte stream into words at ASCII space/punctuation and full-width punctuation.
// The block takes one text byte per cycle at most, and a new one only once its front end has
// settled the last; it gives at most one word byte per cycle. Each accepted item opens a run
// in the front end, which makes one decision per cycle while the queue is not full, on its
// six-byte lookahead window (ASCII delimiter, one of the full-width sequences, or word byte),
// and takes the next item in the cycle that settles the current one. The bytes released by a
// byte that breaks a partial sequence match are decided on one by one; at the last byte of a
// text the front decides on every byte still in the window (a whole sequence is one decision)
// and then on an end marker. A queue of QUEUE_DEPTH decisions lets the front run on while
// the output side is stalled. Each word byte is held until the next decision shows whether it
// ends its word, and a result leaves only once it is known whether it is the last of its run.
// word_number counts from zero within each text and stops at 2^WORD_NUMBER_WIDTH-1; its low
// 16 bits are shown.
module utf8_word_tokenizer_core #(
  parameter int WORD_NUMBER_WIDTH = uwt_pkg::WORD_NUMBER_WIDTH_DEF,
  parameter int QUEUE_DEPTH       = uwt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  uwt_in_if.sink         in_chan,
  uwt_out_if.source      out_chan
);
  import uwt_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  act_t q_in_item, q_out_item;
  res_t res;

  uwt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_byte  (in_chan.text_byte),
    .in_eot   (in_chan.end_of_text),
    .q_push   (q_push),
    .q_item   (q_in_item),
    .q_full   (q_full)
  );

  uwt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .not_empty (q_valid)
  );

  uwt_back #(
    .WORD_NUMBER_WIDTH (WORD_NUMBER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out_item),
    .q_pop     (q_pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  assign out_chan.word_byte     = res.word_byte;
  assign out_chan.first_of_word = res.first_of_word;
  assign out_chan.last_of_word  = res.last_of_word;
  assign out_chan.word_number   = res.word_number;
  assign out_chan.last_of_run   = res.last_of_run;

endmodule

### src/uwt_checker.sv
// Port-level assertions for the word tokenizer, bound to the top level.
module uwt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input uwt_pkg::byte_t                 word_byte,
  input logic                           first_of_word,
  input logic                           last_of_word,
  input logic [uwt_pkg::WORD_NUM_W-1:0] word_number,
  input logic                           last_of_run
);
  import uwt_pkg::*;

  logic                  out_acc;
  logic                  prev_last_r;
  logic [WORD_NUM_W-1:0] prev_num_r;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_last_r <= 1'b1;
      prev_num_r  <= '0;
    end else if (out_acc) begin
      prev_last_r <= last_of_word;
      prev_num_r  <= word_number;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({word_byte, first_of_word, last_of_word, word_number, last_of_run}))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_word_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> first_of_word == prev_last_r)
    else $error("word start does not follow a word end");

  a_word_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !first_of_word |-> word_number == prev_num_r)
    else $error("word number changed inside a word");

endmodule

bind utf8_word_tokenizer_core uwt_checker u_uwt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .word_byte     (out_chan.word_byte),
  .first_of_word (out_chan.first_of_word),
  .last_of_word  (out_chan.last_of_word),
  .word_number   (out_chan.word_number),
  .last_of_run   (out_chan.last_of_run)
);

### test/uwt_word_checker.sv
// Watches both channels of the word tokenizer, predicts each word byte and checks the results.
module uwt_word_checker #(
  parameter int WORD_NUMBER_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  uwt_in_if    in_chan,
  uwt_out_if   out_chan,
  output int   mismatches,
  output int   due
);
  timeunit 1ns;
  timeprecision 1ps;
  import uwt_pkg::*;

  localparam int NUM_FW = 19;
  localparam int CLS_WAIT = -1;
  localparam int CLS_WORD = 0;
  localparam longint unsigned WORD_MAX = (64'd1 << WORD_NUMBER_WIDTH) - 64'd1;

  // full-width punctuation, left-aligned, first listed wins
  localparam logic [47:0] FW_PUNCT [NUM_FW] = '{
    48'hEFBC8C_000000, 48'hE38082_000000, 48'hEFBC81_000000, 48'hEFBC9F_000000,
    48'hEFBC9B_000000, 48'hEFBC9A_000000, 48'hE38081_000000, 48'hEFBC88_000000,
    48'hEFBC89_000000, 48'hE3808A_000000, 48'hE3808B_000000, 48'hE38090_000000,
    48'hE38091_000000, 48'hE2809C_000000, 48'hE2809D_000000, 48'hE28098_000000,
    48'hE28099_000000, 48'hE28094_E28094, 48'hE280A6_E280A6
  };
  localparam int FW_LEN [NUM_FW] = '{3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 6, 6};

  byte_t           win [6];
  int              win_cnt;
  byte_t           held_byte;
  logic            held_valid;
  logic            held_first;
  longint unsigned word_idx;
  int              run_len;
  res_t            word_bytes_due [$];
  res_t            seen;

  function automatic logic is_ascii_delim(input byte_t c);
    logic alnum;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || (c >= 8'h21 && c <= 8'h7E && !alnum);
  endfunction

  // word byte, delimiter length, or wait for more bytes
  function automatic int head_class(input logic eot);
    int   n;
    logic same;
    if (is_ascii_delim(win[0])) return 1;
    for (int s = 0; s < NUM_FW; s++) begin
      n = (win_cnt < FW_LEN[s]) ? win_cnt : FW_LEN[s];
      same = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (win[k] != FW_PUNCT[s][47-8*k -: 8]) same = 1'b0;
      end
      if (same) begin
        if (win_cnt >= FW_LEN[s]) return FW_LEN[s];
        if (!eot) return CLS_WAIT;
      end
    end
    return CLS_WORD;
  endfunction

  task automatic push_result(input byte_t b, input logic first, input logic last);
    res_t r;
    r.word_byte     = b;
    r.first_of_word = first;
    r.last_of_word  = last;
    r.word_number   = word_idx[15:0];
    r.last_of_run   = 1'b0;
    word_bytes_due.push_back(r);
    run_len++;
  endtask

  task automatic close_word();
    if (held_valid) begin
      push_result(held_byte, held_first, 1'b1);
      held_valid = 1'b0;
      held_first = 1'b0;
      if (word_idx < WORD_MAX) word_idx++;
    end
  endtask

  task automatic tokenize_byte(input byte_t b, input logic eot);
    int   cls;
    int   drop;
    logic waiting;
    res_t tail;
    run_len = 0;
    waiting = 1'b0;
    win[win_cnt] = b;
    win_cnt++;
    while (win_cnt > 0 && !waiting) begin
      cls = head_class(eot);
      if (cls == CLS_WAIT) begin
        waiting = 1'b1;
      end else begin
        if (cls == CLS_WORD) begin
          if (held_valid) push_result(held_byte, held_first, 1'b0);
          held_first = !held_valid;
          held_byte  = win[0];
          held_valid = 1'b1;
          drop = 1;
        end else begin
          close_word();
          drop = cls;
        end
        if (drop > win_cnt) drop = win_cnt;
        for (int i = 0; i + drop < win_cnt; i++) win[i] = win[i+drop];
        win_cnt -= drop;
      end
    end
    if (eot) begin
      close_word();
      word_idx = 0;
      win_cnt = 0;
    end
    if (run_len > 0) begin
      tail = word_bytes_due.pop_back();
      tail.last_of_run = 1'b1;
      word_bytes_due.push_back(tail);
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (word_bytes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected item: byte %h first %b last %b word %0d run_end %b", $realtime,
                 got.word_byte, got.first_of_word, got.last_of_word, got.word_number,
                 got.last_of_run);
    end else begin
      want = word_bytes_due.pop_front();
      if (got.word_byte !== want.word_byte || got.first_of_word !== want.first_of_word ||
          got.last_of_word !== want.last_of_word || got.word_number !== want.word_number ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t mismatch: byte %h/%h first %b/%b last %b/%b word %0d/%0d run_end %b/%b (exp/got)",
                   $realtime, want.word_byte, got.word_byte, want.first_of_word,
                   got.first_of_word, want.last_of_word, got.last_of_word, want.word_number,
                   got.word_number, want.last_of_run, got.last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_cnt    = 0;
      held_byte  = 8'h00;
      held_valid = 1'b0;
      held_first = 1'b0;
      word_idx   = 0;
      mismatches = 0;
      word_bytes_due.delete();
    end else begin
      if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1)
        tokenize_byte(in_chan.text_byte, in_chan.end_of_text);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        seen.word_byte     = out_chan.word_byte;
        seen.first_of_word = out_chan.first_of_word;
        seen.last_of_word  = out_chan.last_of_word;
        seen.word_number   = out_chan.word_number;
        seen.last_of_run   = out_chan.last_of_run;
        check_result(seen);
      end
    end
    due = word_bytes_due.size();
  end

endmodule

### test/utf8_word_tokenizer_core_tb.sv
// Top of the word tokenizer testbench: clock, reset, text stimulus, output stalls and verdict.
module utf8_word_tokenizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uwt_pkg::*;

  logic  clk;
  logic  rst_n;
  int    mismatches;
  int    due;
  int    sent;
  logic  in_quiet;
  byte_t text_buf [$];

  uwt_in_if  in_c ();
  uwt_out_if out_c ();

  utf8_word_tokenizer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_c),
    .out_chan (out_c)
  );

  uwt_word_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_c),
    .out_chan   (out_c),
    .mismatches (mismatches),
    .due        (due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // result side: random stall before each item, quiet stretches now and then
  initial begin
    int   gap;
    int   n;
    logic out_quiet;
    out_c.ready = 1'b0;
    n = 0;
    out_quiet = 1'b0;
    @(negedge clk);
    forever begin
      if (n % 32 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      gap = out_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_c.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_c.ready <= 1'b1;
      do @(posedge clk); while (out_c.valid !== 1'b1);
      @(negedge clk);
      n++;
    end
  end

  task automatic put_byte(input byte_t b, input logic eot);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_c.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_c.valid       <= 1'b1;
    in_c.text_byte   <= b;
    in_c.end_of_text <= eot;
    do @(posedge clk); while (in_c.ready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) put_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  function automatic byte_t word_char();
    case ($urandom_range(0, 4))
      0:       return byte_t'(8'h61 + $urandom_range(0, 25));
      1:       return byte_t'(8'h41 + $urandom_range(0, 25));
      2:       return byte_t'(8'h30 + $urandom_range(0, 9));
      3:       return byte_t'($urandom_range(8'h80, 8'hFF));
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_t delim_char();
    case ($urandom_range(0, 4))
      0:       return 8'h20;
      1:       return byte_t'($urandom_range(8'h09, 8'h0D));
      2:       return byte_t'($urandom_range(8'h21, 8'h2F));
      3:       return byte_t'($urandom_range(8'h3A, 8'h40));
      default: return ($urandom_range(0, 1) == 0) ? byte_t'($urandom_range(8'h5B, 8'h60))
                                                  : byte_t'($urandom_range(8'h7B, 8'h7E));
    endcase
  endfunction

  // third byte of a full-width mark, with near misses mixed in
  function automatic byte_t fw_tail();
    case ($urandom_range(0, 19))
      0:       return 8'h8C;
      1:       return 8'h81;
      2:       return 8'h9F;
      3:       return 8'h9B;
      4:       return 8'h9A;
      5:       return 8'h88;
      6:       return 8'h89;
      7:       return 8'h82;
      8:       return 8'h8A;
      9:       return 8'h8B;
      10:      return 8'h90;
      11:      return 8'h91;
      12:      return 8'h9C;
      13:      return 8'h9D;
      14:      return 8'h98;
      15:      return 8'h99;
      16:      return 8'h94;
      17:      return 8'hA6;
      default: return byte_t'($urandom_range(8'h80, 8'hBF));
    endcase
  endfunction

  task automatic add_token();
    int    pick;
    int    n;
    byte_t mark;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(word_char());
    end else if (pick < 50) begin
      text_buf.push_back(byte_t'($urandom_range(8'hE4, 8'hE9)));
      text_buf.push_back(byte_t'($urandom_range(8'h80, 8'hBF)));
      text_buf.push_back(byte_t'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 70) begin
      case ($urandom_range(0, 2))
        0:       begin text_buf.push_back(8'hEF); text_buf.push_back(8'hBC); end
        1:       begin text_buf.push_back(8'hE3); text_buf.push_back(8'h80); end
        default: begin text_buf.push_back(8'hE2); text_buf.push_back(8'h80); end
      endcase
      text_buf.push_back(fw_tail());
    end else if (pick < 78) begin
      mark = ($urandom_range(0, 1) == 0) ? 8'h94 : 8'hA6;
      repeat (2) begin
        text_buf.push_back(8'hE2);
        text_buf.push_back(8'h80);
        text_buf.push_back(mark);
      end
    end else if (pick < 88) begin
      text_buf.push_back(delim_char());
    end else if (pick < 95) begin
      // long mark broken part-way
      text_buf.push_back(8'hE2);
      text_buf.push_back(8'h80);
      text_buf.push_back(($urandom_range(0, 1) == 0) ? 8'h94 : 8'hA6);
      if ($urandom_range(0, 1) == 0) text_buf.push_back(8'hE2);
      if ($urandom_range(0, 1) == 0) text_buf.push_back(8'h80);
      text_buf.push_back(word_char());
    end else begin
      text_buf.push_back(byte_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int n;
    int guard;
    in_c.valid       = 1'b0;
    in_c.text_byte   = 8'h00;
    in_c.end_of_text = 1'b0;
    rst_n            = 1'b0;
    sent             = 0;
    in_quiet         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    text_buf = '{8'hFF, 8'h09, 8'h7E, 8'h41};
    send_text();
    text_buf = '{8'hEF, 8'hBC, 8'h8C, 8'h30};
    send_text();
    // all-delimiter text
    text_buf = '{8'hE2, 8'h80, 8'h94, 8'hE2, 8'h80, 8'h94};
    send_text();
    // text ends inside a mark
    text_buf = '{8'h61, 8'hE2, 8'h80};
    send_text();
    text_buf = '{8'hE2, 8'h80, 8'h94, 8'h62, 8'h20};
    send_text();
    text_buf = '{8'h00};
    send_text();

    while (sent < 400) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 10);
      repeat (n) add_token();
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       text_buf.push_back(8'hEF);
          1:       begin text_buf.push_back(8'hE3); text_buf.push_back(8'h80); end
          2:       begin
            text_buf.push_back(8'hE2); text_buf.push_back(8'h80); text_buf.push_back(8'h94);
          end
          default: begin
            text_buf.push_back(8'hE2); text_buf.push_back(8'h80); text_buf.push_back(8'hA6);
            text_buf.push_back(8'hE2); text_buf.push_back(8'h80);
          end
        endcase
      end
      send_text();
    end
    in_c.valid <= 1'b0;

    guard = 0;
    while (due != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    if (due != 0) begin
      $display("Verification failed");
      $finish;
    end else begin
      repeat (40) @(negedge clk);
      if (mismatches == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule
